@@ src/oaids_pkg.sv @@
// Package for the ordered array block: operation and status codes,
// and the control word broadcast to the row of storage cells.
// No dependencies.
`default_nettype none

package oaids_pkg;

    // Field widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int IDX_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Operation codes on s_operation
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_FILL   = 3'd5,
        OP_PUSH   = 3'd6,
        OP_POP    = 3'd7
    } op_t;

    // Status codes on m_status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // What every cell does in the execute cycle
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_READ,
        ACT_WRITE,
        ACT_INSERT,
        ACT_DELETE,
        ACT_SEARCH,
        ACT_FILL
    } cell_act_t;

    typedef struct packed {
        cell_act_t act;     // action for this cycle
        logic      update;  // an execute cycle: cells refresh their taps
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/oaids_cell.sv @@
// One storage cell of the ordered array: holds one entry, takes data from
// its left or right neighbor on insert/delete, compares for search.
// Depends on oaids_pkg.
`default_nettype none

module oaids_cell #(
    parameter int INDEX = 0,
    parameter int WIDTH = 32,
    parameter int CMPW  = 6
) (
    input  wire logic                   aclk,
    input  wire oaids_pkg::cell_ctrl_t  ctrl,
    input  wire logic [CMPW-1:0]        pos,
    input  wire logic [CMPW-1:0]        cnt,
    input  wire logic [WIDTH-1:0]       value,
    input  wire logic [WIDTH-1:0]       left_data,
    input  wire logic [WIDTH-1:0]       right_data,
    output logic      [WIDTH-1:0]       data,
    output logic      [WIDTH-1:0]       rd,
    output logic                        hit
);
    import oaids_pkg::*;

    localparam logic [CMPW-1:0] MY_IDX  = CMPW'(INDEX);
    localparam logic [CMPW-1:0] MY_IDX1 = CMPW'(INDEX + 1);

    logic [WIDTH-1:0] data_reg, data_next;
    logic [WIDTH-1:0] rd_reg, rd_next;
    logic             hit_reg, hit_next;
    logic             at_pos, above_pos, live;

    assign at_pos    = (MY_IDX == pos);
    assign above_pos = (MY_IDX > pos);
    assign live      = (MY_IDX < cnt);

    // entry update
    always_comb begin
        data_next = data_reg;
        case (ctrl.act)
            ACT_WRITE: begin
                if (at_pos) data_next = value;
            end
            ACT_INSERT: begin
                if (at_pos) begin
                    data_next = value;
                end else if (above_pos && (MY_IDX <= cnt)) begin
                    data_next = left_data;
                end
            end
            ACT_DELETE: begin
                if (!above_pos && !at_pos) begin
                    data_next = data_reg;
                end else if (MY_IDX1 < cnt) begin
                    data_next = right_data;
                end
            end
            ACT_FILL: begin
                if (live) data_next = value;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    // read and compare taps, seen before this cycle's update
    always_comb begin
        rd_next  = '0;
        hit_next = 1'b0;
        if (ctrl.act == ACT_READ && at_pos) rd_next = data_reg;
        if (ctrl.act == ACT_SEARCH && live && (data_reg == value)) hit_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.update) begin
            rd_reg  <= rd_next;
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign rd   = rd_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

@@ src/ordered_array_insert_delete_search.sv @@
// Top level of the ordered array: command register, decode and status,
// a row of oaids_cell storage cells, and the reduce/output register.
// Depends on oaids_pkg and oaids_cell.
`default_nettype none

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_valid / s_ready  | s_operation, s_index, s_value
//  m_       | out       | m_valid / m_ready  | m_status, m_read_value, m_found, m_count
//
// Each beat moves through the accept step (into the command register), an execute
// step in which every cell shifts, writes or compares in parallel, and a reduce
// step that ORs the per-cell read and match taps into the output register.
// A new beat is taken as soon as the previous one reaches the output register,
// while that result still waits for m_ready. A stalled output holds the next
// beat in the reduce cycle. Reset clears the count and the control state; the
// entries themselves are not cleared.

module ordered_array_insert_delete_search #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [oaids_pkg::OP_W-1:0]      s_operation,
    input  wire logic [oaids_pkg::IDX_W-1:0]     s_index,
    input  wire logic [oaids_pkg::VAL_W-1:0]     s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [oaids_pkg::STATUS_W-1:0]  m_status,
    output logic      [oaids_pkg::VAL_W-1:0]     m_read_value,
    output logic                                 m_found,
    output logic      [oaids_pkg::COUNT_W-1:0]   m_count
);
    import oaids_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } state_t;

    state_t             state_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WIDTH-1:0]   val_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    status_t            stat_reg, stat_next;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [VAL_W-1:0]   m_rd_reg;
    logic               m_found_reg;
    logic [COUNT_W-1:0] m_count_reg;

    cell_ctrl_t         ctrl;
    cell_act_t          act;
    logic [CMPW-1:0]    pos_x, cnt_x, pos_eff;
    logic               is_full, is_empty, out_free;

    logic [WIDTH-1:0]   cell_data [DEPTH];
    logic [WIDTH-1:0]   cell_rd   [DEPTH];
    logic               cell_hit  [DEPTH];
    logic [WIDTH-1:0]   rd_or;
    logic               hit_or;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // decode the held command against the live count
    always_comb begin
        pos_x     = CMPW'(idx_reg);
        cnt_x     = CMPW'(cnt_reg);
        is_full   = (cnt_x == CMPW'(DEPTH));
        is_empty  = (cnt_reg == '0);
        pos_eff   = pos_x;
        act       = ACT_NONE;
        stat_next = ST_OK;
        cnt_next  = cnt_reg;
        case (op_t'(op_reg))
            OP_READ: begin
                if (pos_x < cnt_x) act = ACT_READ;
                else stat_next = ST_RANGE;
            end
            OP_WRITE: begin
                if (pos_x < cnt_x) act = ACT_WRITE;
                else stat_next = ST_RANGE;
            end
            OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    stat_next = ST_RANGE;
                end else if (is_full) begin
                    stat_next = ST_FULL;
                end else begin
                    act      = ACT_INSERT;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    stat_next = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    stat_next = ST_RANGE;
                end else begin
                    act      = ACT_DELETE;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            OP_SEARCH: begin
                act = ACT_SEARCH;
            end
            OP_FILL: begin
                act = ACT_FILL;
            end
            OP_PUSH: begin
                pos_eff = cnt_x;
                if (is_full) begin
                    stat_next = ST_FULL;
                end else begin
                    act      = ACT_INSERT;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            OP_POP: begin
                pos_eff = cnt_x - CMPW'(1);
                if (is_empty) begin
                    stat_next = ST_EMPTY;
                end else begin
                    act      = ACT_DELETE;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
        ctrl.update = (state_reg == S_EXEC);
        ctrl.act    = (state_reg == S_EXEC) ? act : ACT_NONE;
    end

    // row of cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_data[i+1];
        end
        oaids_cell #(
            .INDEX (i),
            .WIDTH (WIDTH),
            .CMPW  (CMPW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos_eff),
            .cnt        (cnt_x),
            .value      (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd         (cell_rd[i]),
            .hit        (cell_hit[i])
        );
    end

    // OR the per-cell taps; at most one read tap is nonzero
    always_comb begin
        rd_or  = '0;
        hit_or = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or  = rd_or | cell_rd[i];
            hit_or = hit_or | cell_hit[i];
        end
    end

    // sequencer, count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a taken result drops unless the reduce cycle reloads the register
            if (m_valid_reg && m_ready && state_reg != S_REDUCE) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_operation;
                        idx_reg   <= s_index;
                        val_reg   <= WIDTH'(s_value);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    cnt_reg   <= cnt_next;
                    stat_reg  <= stat_next;
                    state_reg <= S_REDUCE;
                end
                S_REDUCE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= stat_reg;
                        m_rd_reg     <= VAL_W'(rd_or);
                        m_found_reg  <= hit_or;
                        m_count_reg  <= COUNT_W'(cnt_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_rd_reg;
    assign m_found      = m_found_reg;
    assign m_count      = m_count_reg;

`ifndef SYNTH
    // count never grows past the array size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(cnt_reg) <= CMPW'(DEPTH))
        else $error("live count above DEPTH");

    // count moves only in an execute cycle, by one at most
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |->
            ($past(state_reg == S_EXEC) &&
             ((cnt_reg == $past(cnt_reg) + CW'(1)) || (cnt_reg == $past(cnt_reg) - CW'(1)))))
        else $error("live count changed outside execute");

    // a result appears only out of the reduce cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_REDUCE))
        else $error("result without reduce cycle");

    // an empty status reports an empty array and no data
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_EMPTY) |->
            (m_count_reg == '0 && m_rd_reg == '0 && !m_found_reg))
        else $error("empty status with live data");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench for ordered_array_insert_delete_search: directed and random array operations,
// each result predicted from a shadow copy of the array and checked field by field.
// Depends on oaids_pkg and the ordered_array_insert_delete_search RTL.

module tb;
    import oaids_pkg::*;

    localparam int DEPTH       = 32;
    localparam int WIDTH       = 32;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 6;

    typedef struct {
        status_t     status;
        logic [31:0] read_value;
        logic        found;
        logic [5:0]  count;
    } array_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [5:0]  s_index;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_read_value;
    logic        m_found;
    logic [5:0]  m_count;

    // Shadow copy of the array and the results still owed by the block
    logic [31:0]   shadow_cells [DEPTH];
    int            shadow_count;
    array_result_t pending_results [$];

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;

    int errors;
    int beats_checked;
    int peak_count;
    int search_hits;
    int status_seen [4];

    ordered_array_insert_delete_search #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_found      (m_found),
        .m_count      (m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("[ordered_array_insert_delete_search] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Insert at pos, shifting later entries up
    function automatic status_t insert_at(int pos, logic [31:0] val);
        int i;
        if (pos > shadow_count) return ST_RANGE;
        if (shadow_count >= DEPTH) return ST_FULL;
        for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[pos] = val;
        shadow_count++;
        if (shadow_count > peak_count) peak_count = shadow_count;
        return ST_OK;
    endfunction

    // Delete at pos, shifting later entries down
    function automatic status_t delete_at(int pos);
        int i;
        if (shadow_count == 0) return ST_EMPTY;
        if (pos >= shadow_count) return ST_RANGE;
        for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
        shadow_count--;
        return ST_OK;
    endfunction

    function automatic array_result_t apply_array_op(op_t op, logic [5:0] idx,
                                                     logic [31:0] val);
        array_result_t r;
        int i;
        r.status     = ST_OK;
        r.read_value = '0;
        r.found      = 1'b0;
        case (op)
            OP_READ: begin
                if (idx < shadow_count) r.read_value = shadow_cells[idx];
                else r.status = ST_RANGE;
            end
            OP_WRITE: begin
                if (idx < shadow_count) shadow_cells[idx] = val;
                else r.status = ST_RANGE;
            end
            OP_INSERT: r.status = insert_at(idx, val);
            OP_DELETE: r.status = delete_at(idx);
            OP_SEARCH: begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_cells[i] == val) r.found = 1'b1;
            end
            OP_FILL: begin
                for (i = 0; i < shadow_count; i++) shadow_cells[i] = val;
            end
            OP_PUSH: r.status = insert_at(shadow_count, val);
            default: r.status = (shadow_count == 0) ? ST_EMPTY : delete_at(shadow_count - 1);
        endcase
        r.count = shadow_count[5:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one beat per call, random gaps before it
    // ---------------------------------------------------------------
    task automatic send_beat(op_t op, logic [5:0] idx, logic [31:0] val);
        array_result_t predicted;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_index     <= idx;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted       = apply_array_op(op, idx, val);
        pending_results = {pending_results, predicted};
    endtask

    // Wait for every owed result, then for the pipeline to settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        array_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d value %h found %0d count %0d",
                         $time, m_status, m_read_value, m_found, m_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, m_status);
                compare_field("read_value", want.read_value, m_read_value);
                compare_field("found", want.found, m_found);
                compare_field("count", want.count, m_count);
                beats_checked++;
                status_seen[want.status]++;
                if (want.found) search_hits++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every operation but push on an empty array
    task automatic test_empty_array();
        send_beat(OP_READ, 6'd0, 32'h1111_1111);
        send_beat(OP_WRITE, 6'd0, 32'h2222_2222);
        send_beat(OP_DELETE, 6'd0, 32'h0);
        send_beat(OP_POP, 6'd0, 32'h0);
        send_beat(OP_SEARCH, 6'd0, 32'h0);
        send_beat(OP_FILL, 6'd0, 32'hDEAD_BEEF);
        send_beat(OP_INSERT, 6'd1, 32'h3333_3333);
    endtask

    // Shifts in the middle and at both ends, extremes of index and value
    task automatic test_shifts();
        send_beat(OP_PUSH, 6'd0, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 6'd0, 32'h0000_0000);
        send_beat(OP_INSERT, 6'd2, 32'h1234_5678);
        send_beat(OP_INSERT, 6'd1, 32'hA5A5_A5A5);
        send_beat(OP_READ, 6'd0, 32'h0);
        send_beat(OP_READ, 6'd3, 32'h0);
        send_beat(OP_READ, 6'd4, 32'h0);
        send_beat(OP_WRITE, 6'd3, 32'h8000_0001);
        send_beat(OP_SEARCH, 6'd0, 32'hA5A5_A5A5);
        send_beat(OP_SEARCH, 6'd0, 32'h5A5A_5A5A);
        send_beat(OP_DELETE, 6'd1, 32'h0);
        send_beat(OP_DELETE, 6'd63, 32'h0);
        send_beat(OP_INSERT, 6'd63, 32'hFFFF_FFFF);
        send_beat(OP_FILL, 6'd0, 32'h5A5A_5A5A);
        send_beat(OP_SEARCH, 6'd0, 32'h5A5A_5A5A);
        send_beat(OP_POP, 6'd0, 32'h0);
        send_beat(OP_READ, 6'd1, 32'h0);
    endtask

    // Fill to capacity with random data, then probe the full array
    task automatic test_capacity();
        while (shadow_count < DEPTH) send_beat(OP_PUSH, 6'($urandom_range(63)), $urandom);
        send_beat(OP_PUSH, 6'd0, $urandom);
        send_beat(OP_INSERT, 6'(DEPTH), $urandom);
        send_beat(OP_INSERT, 6'd0, $urandom);
        send_beat(OP_INSERT, 6'(DEPTH + 1), $urandom);
        send_beat(OP_READ, 6'(DEPTH - 1), 32'h0);
        send_beat(OP_READ, 6'(DEPTH), 32'h0);
        send_beat(OP_WRITE, 6'(DEPTH - 1), $urandom);
        send_beat(OP_SEARCH, 6'd0, shadow_cells[DEPTH-1]);
        send_beat(OP_DELETE, 6'd0, 32'h0);
        send_beat(OP_PUSH, 6'd0, $urandom);
        send_beat(OP_DELETE, 6'(DEPTH - 1), 32'h0);
    endtask

    // Random operations, swinging between growing and shrinking the array
    task automatic random_beats(int n);
        op_t         op;
        logic [5:0]  idx;
        logic [31:0] val;
        int          roll;
        int          k;
        bit          growing;
        growing = 1'b1;
        for (k = 0; k < n; k++) begin
            if (shadow_count == DEPTH && $urandom_range(7) == 0) growing = 1'b0;
            else if (shadow_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
            else if ($urandom_range(59) == 0) growing = !growing;

            roll = $urandom_range(99);
            if (growing)
                op = roll < 30 ? OP_PUSH : roll < 55 ? OP_INSERT : roll < 65 ? OP_READ :
                     roll < 73 ? OP_WRITE : roll < 79 ? OP_DELETE : roll < 85 ? OP_POP :
                     roll < 94 ? OP_SEARCH : OP_FILL;
            else
                op = roll < 28 ? OP_POP : roll < 56 ? OP_DELETE : roll < 66 ? OP_READ :
                     roll < 74 ? OP_WRITE : roll < 80 ? OP_PUSH : roll < 86 ? OP_INSERT :
                     roll < 95 ? OP_SEARCH : OP_FILL;

            // mostly legal positions, some edges and some anywhere in the field
            roll = $urandom_range(9);
            if (roll == 0)
                idx = 6'($urandom_range(63));
            else if (roll == 1)
                case ($urandom_range(3))
                    0: idx = 6'd0;
                    1: idx = 6'(shadow_count);
                    2: idx = 6'(DEPTH);
                    default: idx = 6'd63;
                endcase
            else if (op == OP_INSERT)
                idx = 6'($urandom_range(shadow_count));
            else
                idx = (shadow_count > 0) ? 6'($urandom_range(shadow_count - 1)) : 6'd0;

            // small pool so searches hit, extremes, live values, full range
            roll = $urandom_range(9);
            if ((op == OP_SEARCH || roll == 3) && shadow_count > 0 && $urandom_range(1) == 1)
                val = shadow_cells[$urandom_range(shadow_count - 1)];
            else if (roll < 3)
                val = 32'($urandom_range(7));
            else if (roll == 4)
                val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            else
                val = $urandom;

            send_beat(op, idx, val);
        end
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        int saved_idle;
        saved_idle   = src_idle_pct;
        src_idle_pct = 0;
        hold_req     = 1'b1;
        random_beats(16);
        src_idle_pct = saved_idle;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_READ;
        s_index       = '0;
        s_value       = '0;
        hold_req      = 1'b0;
        shadow_count  = 0;
        errors        = 0;
        beats_checked = 0;
        peak_count    = 0;
        search_hits   = 0;
        status_seen   = '{0, 0, 0, 0};
        src_idle_pct  = 27;
        sink_idle_pct = 87;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_array();
        test_shifts();
        test_capacity();
        random_beats(220);
        drain();

        src_idle_pct  = 87;
        sink_idle_pct = 27;
        test_backpressure();
        random_beats(220);
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_beats(220);
        drain();

        $display("Checked %0d result beats, peak occupancy %0d, %0d search hits.",
                 beats_checked, peak_count, search_hits);
        $display("Statuses seen: ok %0d, out of range %0d, full %0d, empty %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
                 status_seen[ST_EMPTY]);
        if (errors == 0) begin
            $display("[ordered_array_insert_delete_search] OK");
        end else begin
            $display("[ordered_array_insert_delete_search] ERROR");
        end
        $finish;
    end

endmodule
